/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the keypad scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MKS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("keypad scanner check failed");

// Check a property with its own message.
`define MKS_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

`endif

/* rtl/mks_pkg.sv */
// Package for the keypad scanner: register map, reset values and key map.
`timescale 1ns / 1ps

package mks_pkg;

  // Field widths
  localparam int unsigned ColW     = 4;
  localparam int unsigned RowW     = 4;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned SettleW  = 8;
  localparam int unsigned DebW     = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  // Register indexes (byte address bit 2 selects the register)
  localparam logic RegSettle   = 1'b0;
  localparam logic RegDebounce = 1'b1;

  // Reset values
  localparam logic [SettleW-1:0] SettleReset   = 8'd5;
  localparam logic [DebW-1:0]    DebounceReset = 16'd50000;

  // Map a row and column to its key code
  function automatic logic [CodeW-1:0] key_map(input logic [1:0] row, input logic [1:0] col);
    logic [CodeW-1:0] code;
    case ({row, col})
      4'd0:    code = 4'd7;
      4'd1:    code = 4'd8;
      4'd2:    code = 4'd9;
      4'd3:    code = 4'd10;
      4'd4:    code = 4'd4;
      4'd5:    code = 4'd5;
      4'd6:    code = 4'd6;
      4'd7:    code = 4'd11;
      4'd8:    code = 4'd1;
      4'd9:    code = 4'd2;
      4'd10:   code = 4'd3;
      4'd11:   code = 4'd12;
      4'd12:   code = 4'd15;
      4'd13:   code = 4'd0;
      4'd14:   code = 4'd14;
      default: code = 4'd13;
    endcase
    return code;
  endfunction

endpackage

/* rtl/matrix_keypad_scanner.sv */
// Top level of the 4x4 matrix keypad scanner.
`timescale 1ns / 1ps

// Usage:
//   Input stream: one transaction per time tick, tdata[3:0] holds the sampled
//   column levels (active low, bit i is column i+1).
//   Output stream: one transaction per input tick. tdata[3:0] is the row drive
//   for that tick (one bit low), tdata[7:4] the key code, tuser the key-valid
//   flag, high on the one tick a debounced key is reported.
//   Timing: a result appears on the output in the cycle after its tick is taken.
//   Throughput: one tick per cycle while the receiver keeps tready high; the
//   scan state machine and the tick counter update on each accepted tick, and
//   the output register decouples the two sides.
//   Stall: while the receiver holds tready low with a result pending, the
//   input is held off; one result waits in the output register.
//   Reset: scanning restarts at row 1, counters clear, settle_ticks = 5 and
//   debounce_ticks = 50000.
//   Configuration: APB writes at 0x0 (settle_ticks) and 0x4 (debounce_ticks),
//   done while no tick is in flight. pready is tied high.
module matrix_keypad_scanner
  import mks_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Tick stream in
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [3:0] column_levels, [7:4] zero
  // Result stream out
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [3:0] row_drive, [7:4] key_code
  output logic             m_axis_tuser,   // [0] key_valid
  // Configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_RELEASE  = 2'd1,
    PH_DEBOUNCE = 2'd2
  } phase_e;

  // Configuration registers
  logic [SettleW-1:0] settle_q;
  logic [DebW-1:0]    debounce_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= SettleReset;
      debounce_q <= DebounceReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegSettle) begin
        settle_q <= pwdata[SettleW-1:0];
      end else begin
        debounce_q <= pwdata[DebW-1:0];
      end
    end
  end

  // Read back the selected register
  always_comb begin
    if (paddr[2] == RegSettle) begin
      prdata = {{(DataW-SettleW){1'b0}}, settle_q};
    end else begin
      prdata = {{(DataW-DebW){1'b0}}, debounce_q};
    end
  end

  // Scan state
  phase_e             phase_q, phase_d;
  logic [1:0]         row_q, row_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [1:0]         held_q, held_d;
  logic [CodeW-1:0]   found_q, found_d;

  // Output register
  logic               out_valid_q;
  logic [RowW-1:0]    row_drive_q, row_drive_d;
  logic               key_valid_q, key_valid_d;
  logic [CodeW-1:0]   key_code_q, key_code_d;

  logic [ColW-1:0]    cols;
  logic               hit;
  logic [1:0]         hit_col;
  logic               take;

  assign cols          = s_axis_tdata[ColW-1:0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid & s_axis_tready;

  // Find the first pressed column, column 1 first
  always_comb begin
    hit     = 1'b1;
    hit_col = 2'd0;
    if (!cols[0]) begin
      hit_col = 2'd0;
    end else if (!cols[1]) begin
      hit_col = 2'd1;
    end else if (!cols[2]) begin
      hit_col = 2'd2;
    end else if (!cols[3]) begin
      hit_col = 2'd3;
    end else begin
      hit = 1'b0;
    end
  end

  // Next state and result for one tick
  always_comb begin
    phase_d     = phase_q;
    row_d       = row_q;
    count_d     = count_q;
    held_d      = held_q;
    found_d     = found_q;
    row_drive_d = ~(RowW'(1) << row_q);
    key_valid_d = 1'b0;
    key_code_d  = '0;
    unique case (phase_q)
      PH_SCAN: begin
        if (count_q < {{(CountW-SettleW){1'b0}}, settle_q}) begin
          count_d = count_q + CountW'(1);
        end else begin
          if (hit) begin
            held_d  = hit_col;
            found_d = key_map(row_q, hit_col);
            phase_d = PH_RELEASE;
          end else begin
            row_d = row_q + 2'd1;
          end
          count_d = '0;
        end
      end
      PH_RELEASE: begin
        if (cols[held_q]) begin
          phase_d = PH_DEBOUNCE;
          count_d = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (count_q < debounce_q) begin
          count_d = count_q + CountW'(1);
        end else begin
          key_valid_d = 1'b1;
          key_code_d  = found_q;
          phase_d     = PH_SCAN;
          row_d       = 2'd0;
          count_d     = '0;
        end
      end
      default: begin
        phase_d = PH_SCAN;
        row_d   = 2'd0;
        count_d = '0;
      end
    endcase
  end

  // Hold state and the registered result; advance on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SCAN;
      row_q       <= 2'd0;
      count_q     <= '0;
      held_q      <= 2'd0;
      found_q     <= '0;
      out_valid_q <= 1'b0;
      row_drive_q <= '1;
      key_valid_q <= 1'b0;
      key_code_q  <= '0;
    end else begin
      if (take) begin
        phase_q     <= phase_d;
        row_q       <= row_d;
        count_q     <= count_d;
        held_q      <= held_d;
        found_q     <= found_d;
        out_valid_q <= 1'b1;
        row_drive_q <= row_drive_d;
        key_valid_q <= key_valid_d;
        key_code_q  <= key_code_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {key_code_q, row_drive_q};
  assign m_axis_tuser  = key_valid_q;

endmodule

/* rtl/mks_checker.sv */
// Port-level checks for the keypad scanner, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mks_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       s_axis_tready
);

  // Exactly one row is driven low in every result
  `MKS_ASSERT(one_row_low, clk_i, rst_ni, m_axis_tvalid |-> $countones(m_axis_tdata[3:0]) == 3)

  // No code shows without a reported key
  `MKS_ASSERT_MSG(code_zero_idle, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[7:4] == 4'd0, "key code without key_valid")

  // A pending result holds while the receiver stalls
  `MKS_ASSERT(stall_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

  // Input is held off while a result is stuck in the output register
  `MKS_ASSERT(stall_backpressure, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)

endmodule

bind matrix_keypad_scanner mks_checker u_mks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .s_axis_tready (s_axis_tready)
);
